// File: rtl/ccd_pkg.sv
// Shared types, constants and helpers for the charge-complete detector.
// Used by ccd_regs, ccd_ring and charge_complete_detector; no dependencies.
package ccd_pkg;

    localparam int SAMPLE_COUNT = 8;
    localparam int RING_AW      = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int FILL_W       = $clog2(SAMPLE_COUNT + 1);
    localparam int APB_AW       = 5;

    localparam logic signed [15:0] DELTA_MAX = 16'sd32767;
    localparam logic signed [15:0] DELTA_MIN = -16'sd32767;

    typedef enum logic [1:0] {
        MODE_TICK        = 2'd0,
        MODE_MANUAL_SET  = 2'd1,
        MODE_MANUAL_DONE = 2'd2,
        MODE_CLEAR       = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_CHARGING = 2'd1,
        PH_COMPLETE = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        REG_SAMPLE_PERIOD = 3'd0,
        REG_RISE_THRESH   = 3'd1,
        REG_FLAT_THRESH   = 3'd2,
        REG_DROP_THRESH   = 3'd3,
        REG_FULL_PERCENT  = 3'd4,
        REG_FULL_VOLTAGE  = 3'd5,
        REG_MANUAL_HOLD   = 3'd6,
        REG_CHIME_HOLD    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] now_ms;
        logic [15:0] voltage_mv;
        logic [6:0]  percent;
        logic        charging_on;
    } in_item_t;

    typedef struct packed {
        phase_t             phase;
        logic               chime;
        logic               sampled;
        logic signed [15:0] delta_mv;
    } out_item_t;

    typedef struct packed {
        logic [15:0] sample_period_ms;
        logic [14:0] rise_threshold_mv;
        logic [14:0] flat_threshold_mv;
        logic [14:0] drop_threshold_mv;
        logic [6:0]  full_percent;
        logic [15:0] full_voltage_mv;
        logic [31:0] manual_hold_ms;
        logic [31:0] chime_hold_ms;
    } cfg_t;

    function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] a);
        ring_inc = (a == RING_AW'(SAMPLE_COUNT - 1)) ? '0 : a + 1'b1;
    endfunction

endpackage

// File: rtl/ccd_regs.sv
// APB configuration registers of the charge-complete detector.
// Depends on ccd_pkg (cfg_t, reg_idx_t, APB_AW).
module ccd_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ccd_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output ccd_pkg::cfg_t              cfg
);

    ccd_pkg::cfg_t     cfg_reg;
    ccd_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = ccd_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_period_ms  <= 16'd1000;
            cfg_reg.rise_threshold_mv <= 15'd30;
            cfg_reg.flat_threshold_mv <= 15'd5;
            cfg_reg.drop_threshold_mv <= 15'd40;
            cfg_reg.full_percent      <= 7'd95;
            cfg_reg.full_voltage_mv   <= 16'd4150;
            cfg_reg.manual_hold_ms    <= 32'd10000;
            cfg_reg.chime_hold_ms     <= 32'd60000;
        end else if (wr_en) begin
            unique case (idx)
                ccd_pkg::REG_SAMPLE_PERIOD: cfg_reg.sample_period_ms  <= pwdata[15:0];
                ccd_pkg::REG_RISE_THRESH:   cfg_reg.rise_threshold_mv <= pwdata[14:0];
                ccd_pkg::REG_FLAT_THRESH:   cfg_reg.flat_threshold_mv <= pwdata[14:0];
                ccd_pkg::REG_DROP_THRESH:   cfg_reg.drop_threshold_mv <= pwdata[14:0];
                ccd_pkg::REG_FULL_PERCENT:  cfg_reg.full_percent      <= pwdata[6:0];
                ccd_pkg::REG_FULL_VOLTAGE:  cfg_reg.full_voltage_mv   <= pwdata[15:0];
                ccd_pkg::REG_MANUAL_HOLD:   cfg_reg.manual_hold_ms    <= pwdata;
                ccd_pkg::REG_CHIME_HOLD:    cfg_reg.chime_hold_ms     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            ccd_pkg::REG_SAMPLE_PERIOD: prdata = {16'd0, cfg_reg.sample_period_ms};
            ccd_pkg::REG_RISE_THRESH:   prdata = {17'd0, cfg_reg.rise_threshold_mv};
            ccd_pkg::REG_FLAT_THRESH:   prdata = {17'd0, cfg_reg.flat_threshold_mv};
            ccd_pkg::REG_DROP_THRESH:   prdata = {17'd0, cfg_reg.drop_threshold_mv};
            ccd_pkg::REG_FULL_PERCENT:  prdata = {25'd0, cfg_reg.full_percent};
            ccd_pkg::REG_FULL_VOLTAGE:  prdata = {16'd0, cfg_reg.full_voltage_mv};
            ccd_pkg::REG_MANUAL_HOLD:   prdata = cfg_reg.manual_hold_ms;
            ccd_pkg::REG_CHIME_HOLD:    prdata = cfg_reg.chime_hold_ms;
            default:                    prdata = '0;
        endcase
    end

endmodule

// File: rtl/ccd_ring.sv
// Voltage sample ring: one write port, one registered read port,
// write-to-read forwarding on a same-address hit. Depends on ccd_pkg.
module ccd_ring (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ccd_pkg::RING_AW-1:0] wr_addr,
    input  logic [15:0]                 wr_data,
    input  logic [ccd_pkg::RING_AW-1:0] rd_addr,
    output logic [15:0]                 rd_data
);

    logic [15:0] mem [ccd_pkg::SAMPLE_COUNT];
    logic [15:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/charge_complete_detector.sv
// Charge-complete detector top level. Depends on ccd_pkg, ccd_regs, ccd_ring.
// A result item is registered in m_item_reg, or in the skid stage while stalled.
// Throughput: one item per cycle while the skid is empty; the ring is read ahead at the next
// oldest entry, so each item finds its oldest sample already registered.
// Output register plus a skid stage; s_ready depends only on the skid state.
// Reset: aresetn clears phase, flags, ring pointers and hold ends, sets config defaults;
// the ring memory itself is not cleared (the fill count guards it).
module charge_complete_detector (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ccd_pkg::in_item_t          s_item,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ccd_pkg::out_item_t         m_item,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ccd_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int AW = ccd_pkg::RING_AW;
    localparam int FW = ccd_pkg::FILL_W;

    ccd_pkg::cfg_t cfg;

    ccd_pkg::phase_t    phase_reg, phase_next;
    logic               fired_reg, fired_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [31:0]        last_time_reg, last_time_next;
    logic [31:0]        man_end_reg, man_end_next;
    logic [31:0]        chime_end_reg, chime_end_next;
    logic signed [15:0] delta_reg, delta_next;

    logic               acc;
    logic               take_sample;
    logic [31:0]        elapsed;
    logic [FW-1:0]      fill_inc;
    logic               full_after;
    logic [15:0]        oldest;
    logic signed [16:0] diff;
    logic signed [15:0] diff_sat;
    logic signed [15:0] window_d;
    logic signed [16:0] drop_sum;
    logic               judge;
    logic               rise_hit, flat_hit, drop_hit, full_hit;
    logic               fire_req, chime;
    ccd_pkg::out_item_t result;

    logic               m_valid_reg, skid_valid_reg;
    ccd_pkg::out_item_t m_item_reg, skid_item_reg;

    ccd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ccd_ring u_ring (
        .aclk    (aclk),
        .wr_en   (take_sample),
        .wr_addr (head_reg),
        .wr_data (s_item.voltage_mv),
        .rd_addr (ccd_pkg::ring_inc(head_next)),
        .rd_data (oldest)
    );

    assign s_ready = !skid_valid_reg;
    assign acc     = s_valid && s_ready;

    assign elapsed     = s_item.now_ms - last_time_reg;
    assign take_sample = acc && (s_item.mode == ccd_pkg::MODE_TICK)
                         && (elapsed >= {16'd0, cfg.sample_period_ms});

    assign fill_inc   = (fill_reg == FW'(ccd_pkg::SAMPLE_COUNT)) ? fill_reg : fill_reg + 1'b1;
    assign full_after = (fill_inc == FW'(ccd_pkg::SAMPLE_COUNT));

    // newest is the voltage being written; oldest is the entry after head
    assign diff     = $signed({1'b0, s_item.voltage_mv}) - $signed({1'b0, oldest});
    assign diff_sat = (diff > 17'sd32767)  ? ccd_pkg::DELTA_MAX :
                      (diff < -17'sd32767) ? ccd_pkg::DELTA_MIN : diff[15:0];
    assign window_d = full_after ? diff_sat : '0;

    assign judge = take_sample && full_after
                   && (s_item.now_ms >= man_end_reg) && (s_item.now_ms >= chime_end_reg);

    assign drop_sum = $signed({window_d[15], window_d})
                      + $signed({2'b00, cfg.drop_threshold_mv});
    assign rise_hit = window_d >= $signed({1'b0, cfg.rise_threshold_mv});
    assign flat_hit = window_d < $signed({1'b0, cfg.flat_threshold_mv});
    assign drop_hit = drop_sum <= 17'sd0;
    assign full_hit = (s_item.percent >= cfg.full_percent)
                      || (s_item.voltage_mv >= cfg.full_voltage_mv);

    // phase next state
    always_comb begin
        phase_next = phase_reg;
        if (acc) begin
            unique case (s_item.mode)
                ccd_pkg::MODE_MANUAL_SET:
                    phase_next = s_item.charging_on ? ccd_pkg::PH_CHARGING : ccd_pkg::PH_IDLE;
                ccd_pkg::MODE_MANUAL_DONE: phase_next = ccd_pkg::PH_COMPLETE;
                ccd_pkg::MODE_CLEAR:       phase_next = ccd_pkg::PH_IDLE;
                ccd_pkg::MODE_TICK: begin
                    if (judge) begin
                        unique case (phase_reg)
                            ccd_pkg::PH_IDLE:
                                if (rise_hit) phase_next = ccd_pkg::PH_CHARGING;
                            ccd_pkg::PH_CHARGING:
                                if (flat_hit && full_hit) phase_next = ccd_pkg::PH_COMPLETE;
                            ccd_pkg::PH_COMPLETE:
                                if (drop_hit) phase_next = ccd_pkg::PH_IDLE;
                            default: phase_next = ccd_pkg::PH_IDLE;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // chime, holds, ring pointers
    always_comb begin
        fire_req = acc && ((s_item.mode == ccd_pkg::MODE_MANUAL_DONE)
                   || (judge && (phase_reg == ccd_pkg::PH_CHARGING) && flat_hit && full_hit));
        chime          = fire_req && !fired_reg;
        fired_next     = fired_reg;
        man_end_next   = man_end_reg;
        chime_end_next = chime_end_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        last_time_next = last_time_reg;
        delta_next     = delta_reg;

        if (acc) begin
            unique case (s_item.mode)
                ccd_pkg::MODE_MANUAL_SET: begin
                    man_end_next = s_item.now_ms + cfg.manual_hold_ms;
                    fired_next   = 1'b0;
                end
                ccd_pkg::MODE_MANUAL_DONE: begin
                    man_end_next = s_item.now_ms + cfg.manual_hold_ms;
                end
                ccd_pkg::MODE_CLEAR: begin
                    fired_next     = 1'b0;
                    man_end_next   = '0;
                    chime_end_next = '0;
                    head_next      = '0;
                    fill_next      = '0;
                    delta_next     = '0;
                end
                ccd_pkg::MODE_TICK: begin
                    if (take_sample) begin
                        head_next      = ccd_pkg::ring_inc(head_reg);
                        fill_next      = fill_inc;
                        last_time_next = s_item.now_ms;
                        delta_next     = window_d;
                    end
                    if (judge && (phase_reg == ccd_pkg::PH_IDLE) && rise_hit) begin
                        fired_next = 1'b0;
                    end
                    if (judge && (phase_reg == ccd_pkg::PH_COMPLETE) && drop_hit) begin
                        fired_next = 1'b0;
                    end
                end
                default: ;
            endcase
            if (chime) begin
                fired_next     = 1'b1;
                chime_end_next = s_item.now_ms + cfg.chime_hold_ms;
            end
        end
    end

    always_comb begin
        result.phase    = phase_next;
        result.chime    = chime;
        result.sampled  = take_sample;
        result.delta_mv = delta_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ccd_pkg::PH_IDLE;
            fired_reg     <= 1'b0;
            head_reg      <= '0;
            fill_reg      <= '0;
            last_time_reg <= '0;
            man_end_reg   <= '0;
            chime_end_reg <= '0;
            delta_reg     <= '0;
        end else begin
            phase_reg     <= phase_next;
            fired_reg     <= fired_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            last_time_reg <= last_time_next;
            man_end_reg   <= man_end_next;
            chime_end_reg <= chime_end_next;
            delta_reg     <= delta_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= acc;
            end
        end else if (acc) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_item_reg <= skid_item_reg;
            end else if (acc) begin
                m_item_reg <= result;
            end
        end else if (acc) begin
            skid_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: bench/charge_detector_checker.sv
// Scoreboard for the charge-complete detector: follows the APB register writes,
// predicts each result item from the accepted input items and compares in order.
// Depends on ccd_pkg.
module charge_detector_checker
    import ccd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  in_item_t          s_item,
    input  logic              m_valid,
    input  logic              m_ready,
    input  out_item_t         m_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                pending,
    output int                failures
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t        cfg;
    phase_t      phase;
    logic        fired;
    logic [15:0] ring [SAMPLE_COUNT];
    int          head;
    int          fill;
    logic [31:0] last_sample_ms;
    logic [31:0] manual_end_ms;
    logic [31:0] chime_end_ms;
    out_item_t   due_reports [$];
    int          error_count;

    function automatic void clear_detector();
        phase = PH_IDLE;
        fired = 1'b0;
        foreach (ring[i]) ring[i] = '0;
        head = 0;
        fill = 0;
        manual_end_ms = '0;
        chime_end_ms = '0;
    endfunction

    // newest minus oldest, clamped to +-32767
    function automatic int window_delta();
        int d;
        if (fill < SAMPLE_COUNT) return 0;
        d = int'(ring[(head + SAMPLE_COUNT - 1) % SAMPLE_COUNT]) - int'(ring[head]);
        if (d > 32767) d = 32767;
        if (d < -32767) d = -32767;
        return d;
    endfunction

    function automatic logic fire_chime(logic [31:0] now_ms);
        if (fired) return 1'b0;
        fired = 1'b1;
        chime_end_ms = now_ms + cfg.chime_hold_ms;
        return 1'b1;
    endfunction

    function automatic out_item_t step_detector(in_item_t it);
        logic        chime;
        logic        sampled;
        logic        full;
        int          d;
        logic [31:0] elapsed;
        out_item_t   r;
        chime = 1'b0;
        sampled = 1'b0;
        elapsed = it.now_ms - last_sample_ms;
        case (it.mode)
            MODE_MANUAL_SET: begin
                manual_end_ms = it.now_ms + cfg.manual_hold_ms;
                phase = it.charging_on ? PH_CHARGING : PH_IDLE;
                fired = 1'b0;
            end
            MODE_MANUAL_DONE: begin
                manual_end_ms = it.now_ms + cfg.manual_hold_ms;
                phase = PH_COMPLETE;
                chime = fire_chime(it.now_ms);
            end
            MODE_CLEAR: begin
                clear_detector();
            end
            default: begin
                if (elapsed >= 32'(cfg.sample_period_ms)) begin
                    last_sample_ms = it.now_ms;
                    sampled = 1'b1;
                    ring[head] = it.voltage_mv;
                    head = (head + 1) % SAMPLE_COUNT;
                    if (fill < SAMPLE_COUNT) fill++;
                    // absolute compares, no wrap
                    if (it.now_ms >= manual_end_ms && it.now_ms >= chime_end_ms &&
                        fill >= SAMPLE_COUNT) begin
                        d = window_delta();
                        case (phase)
                            PH_IDLE: begin
                                if (d >= int'(cfg.rise_threshold_mv)) begin
                                    phase = PH_CHARGING;
                                    fired = 1'b0;
                                end
                            end
                            PH_CHARGING: begin
                                full = (it.percent >= cfg.full_percent) ||
                                       (it.voltage_mv >= cfg.full_voltage_mv);
                                if (d < int'(cfg.flat_threshold_mv) && full) begin
                                    phase = PH_COMPLETE;
                                    chime = fire_chime(it.now_ms);
                                end
                            end
                            default: begin
                                if (d <= -int'(cfg.drop_threshold_mv)) begin
                                    phase = PH_IDLE;
                                    fired = 1'b0;
                                end
                            end
                        endcase
                    end
                end
            end
        endcase
        r.phase = phase;
        r.chime = chime;
        r.sampled = sampled;
        r.delta_mv = 16'(window_delta());
        return r;
    endfunction

    function automatic void write_config(logic [APB_AW-1:0] addr, logic [31:0] data);
        case (reg_idx_t'(addr[4:2]))
            REG_SAMPLE_PERIOD: cfg.sample_period_ms = data[15:0];
            REG_RISE_THRESH:   cfg.rise_threshold_mv = data[14:0];
            REG_FLAT_THRESH:   cfg.flat_threshold_mv = data[14:0];
            REG_DROP_THRESH:   cfg.drop_threshold_mv = data[14:0];
            REG_FULL_PERCENT:  cfg.full_percent = data[6:0];
            REG_FULL_VOLTAGE:  cfg.full_voltage_mv = data[15:0];
            REG_MANUAL_HOLD:   cfg.manual_hold_ms = data;
            REG_CHIME_HOLD:    cfg.chime_hold_ms = data;
            default: ;
        endcase
    endfunction

    task automatic check_field(string name, logic signed [16:0] want, logic signed [16:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            cfg.sample_period_ms = 16'd1000;
            cfg.rise_threshold_mv = 15'd30;
            cfg.flat_threshold_mv = 15'd5;
            cfg.drop_threshold_mv = 15'd40;
            cfg.full_percent = 7'd95;
            cfg.full_voltage_mv = 16'd4150;
            cfg.manual_hold_ms = 32'd10000;
            cfg.chime_hold_ms = 32'd60000;
            clear_detector();
            last_sample_ms = '0;
            due_reports.delete();
            error_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_reports.size() == 0) begin
                    $error("result item with nothing outstanding: phase %0d delta %0d",
                           m_item.phase, m_item.delta_mv);
                    error_count++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("phase", 17'(want.phase), 17'(m_item.phase));
                    check_field("chime", 17'(want.chime), 17'(m_item.chime));
                    check_field("sampled", 17'(want.sampled), 17'(m_item.sampled));
                    check_field("delta_mv", 17'(want.delta_mv), 17'(m_item.delta_mv));
                end
            end
            if (psel && penable && pwrite && pready) write_config(paddr, pwdata);
            if (s_valid && s_ready) due_reports.push_back(step_detector(s_item));
        end
        pending <= due_reports.size();
        failures <= error_count;
    end

endmodule

// File: bench/tb_charge_complete_detector.sv
// Top of the charge-complete detector bench: clock, reset, APB setup, stimulus
// and verdict. Depends on ccd_pkg, charge_complete_detector, charge_detector_checker.
module tb_charge_complete_detector;
    timeunit 1ns;
    timeprecision 1ps;
    import ccd_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_item_t          s_item;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_item;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                pending;
    int                failures;

    int                gap_pct;
    int                stall_pct;
    cfg_t              plan;
    logic [31:0]       clock_ms;
    int                level_mv;
    int                segment;
    int                seg_left;

    charge_complete_detector uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    charge_detector_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .pending(pending), .failures(failures)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
    endtask

    task automatic load_config(cfg_t c);
        plan = c;
        write_reg(REG_SAMPLE_PERIOD, 32'(c.sample_period_ms));
        write_reg(REG_RISE_THRESH, 32'(c.rise_threshold_mv));
        write_reg(REG_FLAT_THRESH, 32'(c.flat_threshold_mv));
        write_reg(REG_DROP_THRESH, 32'(c.drop_threshold_mv));
        write_reg(REG_FULL_PERCENT, 32'(c.full_percent));
        write_reg(REG_FULL_VOLTAGE, 32'(c.full_voltage_mv));
        write_reg(REG_MANUAL_HOLD, c.manual_hold_ms);
        write_reg(REG_CHIME_HOLD, c.chime_hold_ms);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_item(in_item_t it);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_item <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic in_item_t item_of(mode_t m, logic [31:0] t, logic [15:0] v,
                                         logic [6:0] p, logic on);
        in_item_t it;
        it.mode = m;
        it.now_ms = t;
        it.voltage_mv = v;
        it.percent = p;
        it.charging_on = on;
        return it;
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        int unsigned per;
        per = $urandom_range(1, 50);
        c.sample_period_ms = 16'(per);
        c.rise_threshold_mv = 15'($urandom_range(5, 200));
        c.flat_threshold_mv = 15'($urandom_range(1, 40));
        c.drop_threshold_mv = 15'($urandom_range(5, 200));
        c.full_percent = 7'($urandom_range(0, 100));
        c.full_voltage_mv = 16'($urandom_range(3500, 4500));
        c.manual_hold_ms = $urandom_range(0, per * 8);
        c.chime_hold_ms = $urandom_range(0, per * 12);
        return c;
    endfunction

    // mostly rise / plateau / drop sequences on a steady clock, with some noise
    function automatic in_item_t charge_cycle_item();
        int unsigned per;
        int          r;
        int          rise;
        int          drop;
        int          pct_floor;
        in_item_t    it;
        per = 32'(plan.sample_period_ms);
        r = $urandom_range(0, 99);
        if (r < 7) begin
            return item_of(mode_t'($urandom_range(0, 3)), $urandom(), 16'($urandom()),
                           7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        end
        if (r < 10) begin
            return item_of(($urandom_range(0, 1) != 0) ? MODE_MANUAL_SET : MODE_MANUAL_DONE,
                           clock_ms, 16'(level_mv), 7'($urandom_range(0, 100)),
                           1'($urandom_range(0, 1)));
        end
        if (r < 11) begin
            return item_of(MODE_CLEAR, clock_ms, 16'($urandom()), 7'($urandom_range(0, 100)),
                           1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 99) < 15) begin
            clock_ms += $urandom_range(0, per / 2);
        end else begin
            clock_ms += per + $urandom_range(0, per / 4 + 1);
        end
        rise = int'(plan.rise_threshold_mv);
        drop = int'(plan.drop_threshold_mv);
        case (segment)
            0: level_mv += $urandom_range(rise / 4, rise / 2 + 3);
            1: level_mv += int'($urandom_range(0, 2)) - 1;
            default: level_mv -= $urandom_range(drop / 4, drop / 2 + 3);
        endcase
        if (level_mv < 0) level_mv = 0;
        if (level_mv > 65535) level_mv = 65535;
        pct_floor = (plan.full_percent > 100) ? 100 : int'(plan.full_percent);
        it = item_of(MODE_TICK, clock_ms, 16'(level_mv),
                     7'((segment == 1) ? $urandom_range(pct_floor, 100)
                                       : $urandom_range(0, 100)),
                     1'($urandom_range(0, 1)));
        seg_left--;
        if (seg_left <= 0) begin
            segment = (segment + 1) % 3;
            seg_left = $urandom_range(10, 25);
        end
        return it;
    endfunction

    initial begin
        cfg_t c;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gap_pct = 0;
        stall_pct = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero period: every tick samples; tiny holds
        c.sample_period_ms = 16'd0;
        c.rise_threshold_mv = 15'd30;
        c.flat_threshold_mv = 15'd5;
        c.drop_threshold_mv = 15'd40;
        c.full_percent = 7'd95;
        c.full_voltage_mv = 16'hFFFF;
        c.manual_hold_ms = 32'd2;
        c.chime_hold_ms = 32'd1;
        load_config(c);

        push_item(item_of(MODE_TICK, 32'd0, 16'd0, 7'd0, 1'b0));
        for (int i = 1; i < 8; i++) begin
            push_item(item_of(MODE_TICK, 32'(i), 16'hFFFF, 7'd100, 1'b0));
        end
        push_item(item_of(MODE_TICK, 32'd8, 16'hFFFF, 7'd0, 1'b1));
        push_item(item_of(MODE_TICK, 32'd9, 16'd0, 7'd127, 1'b0));
        push_item(item_of(MODE_MANUAL_SET, 32'd10, 16'd0, 7'd0, 1'b1));
        push_item(item_of(MODE_MANUAL_DONE, 32'd11, 16'd0, 7'd0, 1'b0));
        push_item(item_of(MODE_MANUAL_DONE, 32'd12, 16'd0, 7'd0, 1'b0));
        push_item(item_of(MODE_MANUAL_SET, 32'd13, 16'd0, 7'd0, 1'b0));
        push_item(item_of(MODE_TICK, 32'd14, 16'd1234, 7'd64, 1'b1));
        push_item(item_of(MODE_CLEAR, 32'd15, 16'hAAAA, 7'h55, 1'b1));
        // hold end wraps past zero
        push_item(item_of(MODE_MANUAL_SET, 32'hFFFF_FFFF, 16'h5555, 7'h2A, 1'b1));
        push_item(item_of(MODE_TICK, 32'd0, 16'h5555, 7'd100, 1'b0));
        push_item(item_of(MODE_TICK, 32'hFFFF_FFFF, 16'hAAAA, 7'h2A, 1'b1));
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p == 3) begin
                c.sample_period_ms = 16'hFFFF;
                c.rise_threshold_mv = 15'h7FFF;
                c.flat_threshold_mv = 15'h7FFF;
                c.drop_threshold_mv = 15'h7FFF;
                c.full_percent = 7'd100;
                c.full_voltage_mv = 16'hFFFF;
                c.manual_hold_ms = 32'hFFFF_FFFF;
                c.chime_hold_ms = 32'hFFFF_FFFF;
            end else if (p == 6) begin
                c = '0;
                c.sample_period_ms = 16'd1;
            end else begin
                c = random_config();
            end
            load_config(c);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 79; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 79; end
                default: begin gap_pct = 38; stall_pct = 38; end
            endcase
            clock_ms = $urandom();
            level_mv = $urandom_range(3000, 4000);
            segment = 0;
            seg_left = $urandom_range(10, 25);
            repeat (125) push_item(charge_cycle_item());
            drain();
        end

        if (failures == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/ccd_pkg.sv
rtl/ccd_regs.sv
rtl/ccd_ring.sv
rtl/charge_complete_detector.sv
bench/charge_detector_checker.sv
bench/tb_charge_complete_detector.sv
